// ----- rtl/core/pcfs_pkg.sv -----
// ============================================================================
// pcfs_pkg
// Shared constants for the power capped frequency selector: default widths,
// register indexes and register reset values.
// ============================================================================
`default_nettype none

package pcfs_pkg;

    // default field widths
    localparam int unsigned FREQ_BITS_DEF  = 13;
    localparam int unsigned POWER_BITS_DEF = 20;

    // configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 3;
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LINE_FREQ_A  = 3'd0,
        REG_LINE_FREQ_B  = 3'd1,
        REG_LINE_POWER_A = 3'd2,
        REG_LINE_POWER_B = 3'd3,
        REG_LOWEST_FREQ  = 3'd4,
        REG_HIGHEST_FREQ = 3'd5,
        REG_FREQ_STEP    = 3'd6
    } t_cfg_idx;

    // register reset values
    localparam int unsigned RST_LINE_FREQ_A  = 1000;
    localparam int unsigned RST_LINE_FREQ_B  = 4000;
    localparam int unsigned RST_LINE_POWER_A = 256;
    localparam int unsigned RST_LINE_POWER_B = 2560;
    localparam int unsigned RST_LOWEST_FREQ  = 1000;
    localparam int unsigned RST_HIGHEST_FREQ = 4000;
    localparam int unsigned RST_FREQ_STEP    = 100;

endpackage

`default_nettype wire

// ----- rtl/core/power_capped_frequency_select.sv -----
// ============================================================================
// power_capped_frequency_select
// Picks the highest candidate frequency whose predicted static plus dynamic
// power stays within a budget (the lowest if none fits), using exact integer comparisons.
// ============================================================================
// A beat is taken when start is high and busy is low; the result comes back
// as a one-cycle o_done strobe with o_chosen_freq_mhz and cannot be held off,
// so the receiver must sample it in that cycle. A beat runs a setup phase,
// then issues one candidate frequency per cycle into a 4-stage candidate
// pipeline (subtract and multiply, cube, split cross products, wide sum) and
// a compare, then drains the pipeline and raises o_done. Candidates run from
// lowest to highest in steps of freq_step_mhz; busy stays high until o_done
// rises, and the next beat can be taken in the cycle that o_done is high.
// The user must write configuration only while busy is low; the block does not enforce it.
`default_nettype none

module power_capped_frequency_select #(
    parameter int unsigned FREQ_BITS  = pcfs_pkg::FREQ_BITS_DEF,
    parameter int unsigned POWER_BITS = pcfs_pkg::POWER_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [FREQ_BITS-1:0]                  i_present_freq_mhz,
    input  wire logic [POWER_BITS-1:0]                 i_measured_power,
    input  wire logic [POWER_BITS-1:0]                 i_budget_power,
    input  wire logic                                  i_cfg_we,
    input  wire logic [pcfs_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  wire logic [((FREQ_BITS > POWER_BITS) ? FREQ_BITS : POWER_BITS)-1:0] i_cfg_data,
    output logic                                       o_done,
    output logic [FREQ_BITS-1:0]                       o_chosen_freq_mhz
);

    localparam int unsigned FW  = FREQ_BITS;
    localparam int unsigned PW  = POWER_BITS;
    localparam int unsigned MW  = PW + FW + 2;      // signed products
    localparam int unsigned DW  = MW + 1;           // signed differences
    localparam int unsigned UW  = DW - 1;           // magnitude of dyn / room
    localparam int unsigned CW  = 3 * FW;           // cube width
    localparam int unsigned H   = (CW + 1) / 2;     // low split of cube
    localparam int unsigned HH  = CW - H;           // high split of cube
    localparam int unsigned SW  = UW + CW;          // full cross product

    typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_RUN} t_state;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [FW-1:0] r_fa_cfg, r_fb_cfg, r_lo, r_hi, r_step;
    logic [PW-1:0] r_pa_cfg, r_pb_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fa_cfg <= FW'(pcfs_pkg::RST_LINE_FREQ_A);
            r_fb_cfg <= FW'(pcfs_pkg::RST_LINE_FREQ_B);
            r_pa_cfg <= PW'(pcfs_pkg::RST_LINE_POWER_A);
            r_pb_cfg <= PW'(pcfs_pkg::RST_LINE_POWER_B);
            r_lo     <= FW'(pcfs_pkg::RST_LOWEST_FREQ);
            r_hi     <= FW'(pcfs_pkg::RST_HIGHEST_FREQ);
            r_step   <= FW'(pcfs_pkg::RST_FREQ_STEP);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcfs_pkg::REG_LINE_FREQ_A:  r_fa_cfg <= i_cfg_data[FW-1:0];
                pcfs_pkg::REG_LINE_FREQ_B:  r_fb_cfg <= i_cfg_data[FW-1:0];
                pcfs_pkg::REG_LINE_POWER_A: r_pa_cfg <= i_cfg_data[PW-1:0];
                pcfs_pkg::REG_LINE_POWER_B: r_pb_cfg <= i_cfg_data[PW-1:0];
                pcfs_pkg::REG_LOWEST_FREQ:  r_lo     <= i_cfg_data[FW-1:0];
                pcfs_pkg::REG_HIGHEST_FREQ: r_hi     <= i_cfg_data[FW-1:0];
                pcfs_pkg::REG_FREQ_STEP:    r_step   <= i_cfg_data[FW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // line slope, normalized to a positive frequency span
    // ------------------------------------------------------------------------
    logic signed [FW:0] fdiff;
    logic signed [PW:0] pdiff;
    logic [FW-1:0]      n_df;
    logic signed [PW:0] n_dp;

    always_comb begin
        fdiff = $signed({1'b0, r_fb_cfg}) - $signed({1'b0, r_fa_cfg});
        pdiff = $signed({1'b0, r_pb_cfg}) - $signed({1'b0, r_pa_cfg});
        if (fdiff == '0) begin
            n_df = FW'(1);
            n_dp = '0;
        end else if (fdiff < 0) begin
            n_df = FW'(-fdiff);
            n_dp = -pdiff;
        end else begin
            n_df = fdiff[FW-1:0];
            n_dp = pdiff;
        end
    end

    // ------------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------------
    t_state          r_state;
    logic [1:0]      r_cnt;
    logic [FW:0]     r_f;
    logic            r_done;
    logic [FW-1:0]   r_chosen;
    logic            s1_v, s2_v, s3_v, s4_v;
    logic            accept, issue, drained, fits;
    logic [FW:0]     step_ext;

    assign accept   = start && (r_state == ST_IDLE);
    assign issue    = (r_state == ST_RUN) && (r_f <= {1'b0, r_hi});
    assign drained  = !issue && !s1_v && !s2_v && !s3_v && !s4_v;
    assign step_ext = (r_step == '0) ? (FW+1)'(1) : {1'b0, r_step};

    assign busy              = (r_state != ST_IDLE);
    assign o_done            = r_done;
    assign o_chosen_freq_mhz = r_chosen;

    // per-item operands
    logic [FW-1:0]      r_c, r_fa, r_df;
    logic [PW-1:0]      r_pm, r_bud, r_pa;
    logic signed [PW:0] r_dp;

    // hold state, sequence setup, issue candidates, flag the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
            r_f     <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_SETUP;
                        r_cnt   <= '0;
                        r_f     <= {1'b0, r_lo};
                    end
                end
                ST_SETUP: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd2) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (issue) begin
                        r_f <= r_f + step_ext;
                    end else if (drained) begin
                        r_state <= ST_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // latch the beat and the slope
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_c   <= i_present_freq_mhz;
            r_pm  <= i_measured_power;
            r_bud <= i_budget_power;
            r_fa  <= r_fa_cfg;
            r_pa  <= r_pa_cfg;
            r_df  <= n_df;
            r_dp  <= n_dp;
        end
    end

    // ------------------------------------------------------------------------
    // setup chain: dynamic power, budget headroom base, cube of present freq
    // ------------------------------------------------------------------------
    logic signed [PW:0] r_t1, r_bdiff;
    logic signed [FW:0] r_dc;
    logic signed [MW-1:0] r_m1, r_m2, r_bd;
    logic [2*FW-1:0]    r_c2;
    logic [UW-1:0]      r_dyn;
    logic [CW-1:0]      r_c3;
    logic signed [DW-1:0] dyn_s;
    logic signed [FW:0]   df_s;

    assign df_s  = $signed({1'b0, r_df});
    assign dyn_s = DW'(r_m1) - DW'(r_m2);

    always_ff @(posedge i_clk) begin
        r_t1    <= $signed({1'b0, r_pm}) - $signed({1'b0, r_pa});
        r_bdiff <= $signed({1'b0, r_bud}) - $signed({1'b0, r_pa});
        r_dc    <= $signed({1'b0, r_c}) - $signed({1'b0, r_fa});
        r_m1    <= MW'(r_t1) * MW'(df_s);
        r_m2    <= MW'(r_dp) * MW'(r_dc);
        r_bd    <= MW'(r_bdiff) * MW'(df_s);
        r_c2    <= (2*FW)'(r_c) * (2*FW)'(r_c);
        r_dyn   <= (dyn_s < 0 || r_c == '0) ? '0 : dyn_s[UW-1:0];
        r_c3    <= CW'(r_c2) * CW'(r_c);
    end

    // ------------------------------------------------------------------------
    // candidate pipeline
    // ------------------------------------------------------------------------
    logic signed [MW-1:0] s1_m2;
    logic [2*FW-1:0]      s1_f2;
    logic [FW-1:0]        s1_f, s2_f, s3_f, s4_f;
    logic signed [DW-1:0] s2_room;
    logic [CW-1:0]        s2_f3;
    logic [UW+H-1:0]      s3_pl, s3_ql;
    logic [UW+HH-1:0]     s3_ph, s3_qh;
    logic                 s3_neg, s3_dz, s4_neg, s4_dz;
    logic [SW-1:0]        s4_l, s4_r;
    logic signed [FW:0]   fdelta;
    logic [UW-1:0]        room_mag;

    assign fdelta   = $signed({1'b0, r_f[FW-1:0]}) - $signed({1'b0, r_fa});
    assign room_mag = s2_room[UW-1:0];

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            s1_v <= 1'b0;
            s2_v <= 1'b0;
            s3_v <= 1'b0;
            s4_v <= 1'b0;
        end else begin
            s1_v <= issue;
            s2_v <= s1_v;
            s3_v <= s2_v;
            s4_v <= s3_v;
        end
    end

    // advance candidate data
    always_ff @(posedge i_clk) begin
        // static slope term and square
        s1_f   <= r_f[FW-1:0];
        s1_m2  <= MW'(r_dp) * MW'(fdelta);
        s1_f2  <= (2*FW)'(r_f[FW-1:0]) * (2*FW)'(r_f[FW-1:0]);
        // headroom and cube
        s2_f    <= s1_f;
        s2_room <= DW'(r_bd) - DW'(s1_m2);
        s2_f3   <= CW'(s1_f2) * CW'(s1_f);
        // split cross products
        s3_f   <= s2_f;
        s3_neg <= (s2_room < 0);
        s3_dz  <= (r_dyn == '0);
        s3_pl  <= (UW+H)'(r_dyn) * (UW+H)'(s2_f3[H-1:0]);
        s3_ph  <= (UW+HH)'(r_dyn) * (UW+HH)'(s2_f3[CW-1:H]);
        s3_ql  <= (UW+H)'(room_mag) * (UW+H)'(r_c3[H-1:0]);
        s3_qh  <= (UW+HH)'(room_mag) * (UW+HH)'(r_c3[CW-1:H]);
        // wide sums
        s4_f   <= s3_f;
        s4_neg <= s3_neg;
        s4_dz  <= s3_dz;
        s4_l   <= SW'(s3_pl) + (SW'(s3_ph) << H);
        s4_r   <= SW'(s3_ql) + (SW'(s3_qh) << H);
    end

    assign fits = !s4_neg && (s4_dz || (s4_l <= s4_r));

    // keep the last fitting candidate; start from lowest
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_chosen <= r_lo;
        end else if (s4_v && fits) begin
            r_chosen <= s4_f;
        end
    end

endmodule

`default_nettype wire
